// ===== rtl/core/apc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_pkg
// Shared types, codes and constants of the axis positioner controller.
// ----------------------------------------------------------------------------
package apc_pkg;

   localparam int POS_WIDTH_DEFAULT = 32;
   localparam int SPD_WIDTH         = 16;
   localparam int SD_WIDTH          = 24;
   localparam int PROD_WIDTH        = SD_WIDTH + SPD_WIDTH;
   localparam int CSR_IDX_WIDTH     = 3;
   localparam int CSR_DATA_WIDTH    = 32;

   localparam logic [15:0] BAND_RESET        = 16'd10;
   localparam logic [31:0] LIMIT_MIN_RESET   = -32'sd100000;
   localparam logic [31:0] LIMIT_MAX_RESET   = 32'sd100000;
   localparam logic [15:0] HOME_SPEED_RESET  = 16'd100;
   localparam logic [31:0] HOME_OFFSET_RESET = 32'd0;
   localparam logic [15:0] FLOOR_RESET       = 16'd5;
   localparam logic [23:0] SLOWDOWN_RESET    = 24'd1000;

   typedef enum logic [3:0] {
      ACT_ENABLE  = 4'd0,
      ACT_DISABLE = 4'd1,
      ACT_HOME    = 4'd2,
      ACT_MOVE    = 4'd3,
      ACT_STOP    = 4'd4,
      ACT_JOG_FWD = 4'd5,
      ACT_JOG_BCK = 4'd6,
      ACT_TICK    = 4'd7,
      ACT_PULSES  = 4'd8
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE     = 4'd0,
      ST_INPOS    = 4'd1,
      ST_NOTINPOS = 4'd2,
      ST_MOVING   = 4'd3,
      ST_HOMING   = 4'd4,
      ST_JOGF     = 4'd5,
      ST_JOGB     = 4'd6,
      ST_LIMIT    = 4'd7,
      ST_NOREF    = 4'd8
   } status_type;

   typedef enum logic [1:0] {
      MODE_NONE = 2'd0,
      MODE_HOME = 2'd1,
      MODE_POS  = 2'd2,
      MODE_JOG  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      MA_NONE  = 2'd0,
      MA_FWD   = 2'd1,
      MA_BACK  = 2'd2,
      MA_BRAKE = 2'd3
   } motor_type;

   typedef enum logic [1:0] {
      PA_NONE    = 2'd0,
      PA_ENABLE  = 2'd1,
      PA_DISABLE = 2'd2
   } power_type;

   typedef enum logic [2:0] {
      CSR_BAND       = 3'd0,
      CSR_LIMIT_MIN  = 3'd1,
      CSR_LIMIT_MAX  = 3'd2,
      CSR_HOME_SPEED = 3'd3,
      CSR_HOME_OFS   = 3'd4,
      CSR_FLOOR      = 3'd5,
      CSR_SLOWDOWN   = 3'd6,
      CSR_HOME_REV   = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_EVAL,
      FSM_DECIDE,
      FSM_DIV,
      FSM_COMMIT
   } fsm_state_type;

   typedef struct packed {
      logic load;
      logic eval;
      logic div_start;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_done;
      logic out_free;
   } dp_sts_type;

endpackage

// ===== rtl/core/axis_positioner_controller_unit.sv =====
// Sequence: an accepted request is captured, evaluated and then committed to the
//   result register; a positioning tick inside the slowdown distance runs the serial divide first.
// A new request is taken only once the previous one has been committed; a result
//   held by rsp_stall holds the next commit until it is taken.
// Reset: synchronous, active high; clears axis state, the sequencer and the
//   result valid flag and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// axis_positioner_controller_unit
// Single-axis positioner: commands, scan ticks and encoder pulses in, one
// status result per request out.
// ----------------------------------------------------------------------------
module axis_positioner_controller_unit #(
   parameter int POS_WIDTH = apc_pkg::POS_WIDTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // configuration writes
   input  wire logic               csr_wr_en,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_wdata,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [3:0]         req_action,
   input  wire logic signed [31:0] req_goal_position,
   input  wire logic [15:0]        req_requested_speed,
   input  wire logic [15:0]        req_pulse_count,
   input  wire logic               req_home_switch,
   // result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [3:0]              rsp_status_code,
   output logic [1:0]              rsp_motor_action,
   output logic [1:0]              rsp_power_action,
   output logic                    rsp_speed_valid,
   output logic signed [31:0]      rsp_speed_command,
   output logic signed [31:0]      rsp_current_position,
   output logic                    rsp_moving_backward
);
   // Commands flow from the sequencer, status flows back; the datapath owns
   // all axis state and the result register, so a finished result can wait
   // for the consumer while the next request is already being worked on.
   apc_pkg::dp_cmd_type cmd;
   apc_pkg::dp_sts_type sts;

   apc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   apc_dp #(
      .POS_WIDTH(POS_WIDTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_action          (req_action),
      .req_goal_position   (req_goal_position),
      .req_requested_speed (req_requested_speed),
      .req_pulse_count     (req_pulse_count),
      .req_home_switch     (req_home_switch),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status_code     (rsp_status_code),
      .rsp_motor_action    (rsp_motor_action),
      .rsp_power_action    (rsp_power_action),
      .rsp_speed_valid     (rsp_speed_valid),
      .rsp_speed_command   (rsp_speed_command),
      .rsp_current_position(rsp_current_position),
      .rsp_moving_backward (rsp_moving_backward)
   );

`ifndef SYNTH
   // an accepted request keeps the input closed while it is in work
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous one in work");

   // a disable always reports the idle status
   a_disable_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_power_action == apc_pkg::PA_DISABLE)
      |-> (rsp_status_code == apc_pkg::ST_IDLE))
      else $error("disable result without idle status");

   // an enable leaves the axis in one of the enabled rest states
   a_enable_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_power_action == apc_pkg::PA_ENABLE)
      |-> (rsp_status_code == apc_pkg::ST_NOREF || rsp_status_code == apc_pkg::ST_INPOS
           || rsp_status_code == apc_pkg::ST_NOTINPOS))
      else $error("enable result with unexpected status");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/apc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module apc_div #(
   parameter int NUM_W = apc_pkg::PROD_WIDTH,
   parameter int DEN_W = apc_pkg::SD_WIDTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] dividend,
   input  wire logic [DEN_W-1:0] divisor,
   output logic      [NUM_W-1:0] quotient,
   output logic                  done
);
   localparam int CW = $clog2(NUM_W + 1);

   logic [DEN_W:0]   rem_ff,  rem_in;
   logic [NUM_W-1:0] quo_ff,  quo_in;
   logic [DEN_W-1:0] den_ff,  den_in;
   logic [CW-1:0]    cnt_ff,  cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W+1:0] trial;

   always_comb begin
      shifted = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      trial   = {1'b0, shifted} - {2'b00, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         if (trial[DEN_W+1]) begin
            rem_in = shifted;
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end else begin
            rem_in = trial[DEN_W:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule
`default_nettype wire

// ===== rtl/core/apc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apc_ctrl
// Sequencer: take a request, evaluate, divide when needed, commit.
// ----------------------------------------------------------------------------
module apc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire apc_pkg::dp_sts_type sts,
   output apc_pkg::dp_cmd_type      cmd
);
   apc_pkg::fsm_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         apc_pkg::FSM_IDLE:   if (req_valid) state_in = apc_pkg::FSM_EVAL;
         apc_pkg::FSM_EVAL:   state_in = apc_pkg::FSM_DECIDE;
         apc_pkg::FSM_DECIDE: state_in = sts.need_div ? apc_pkg::FSM_DIV
                                                      : apc_pkg::FSM_COMMIT;
         apc_pkg::FSM_DIV:    if (sts.div_done) state_in = apc_pkg::FSM_COMMIT;
         apc_pkg::FSM_COMMIT: if (sts.out_free) state_in = apc_pkg::FSM_IDLE;
         default:             state_in = apc_pkg::FSM_IDLE;
      endcase
   end

   always_comb begin
      req_stall     = (state_ff != apc_pkg::FSM_IDLE);
      cmd.load      = (state_ff == apc_pkg::FSM_IDLE) && req_valid;
      cmd.eval      = (state_ff == apc_pkg::FSM_EVAL);
      cmd.div_start = (state_ff == apc_pkg::FSM_DECIDE) && sts.need_div;
      cmd.commit    = (state_ff == apc_pkg::FSM_COMMIT) && sts.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= apc_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/apc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apc_dp
// Axis state, configuration registers, step arithmetic and result register.
// ----------------------------------------------------------------------------
module apc_dp #(
   parameter int POS_WIDTH = apc_pkg::POS_WIDTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire apc_pkg::dp_cmd_type cmd,
   output apc_pkg::dp_sts_type      sts,
   input  wire logic                csr_wr_en,
   input  wire logic [2:0]          csr_index,
   input  wire logic [31:0]         csr_wdata,
   input  wire logic [3:0]          req_action,
   input  wire logic signed [31:0]  req_goal_position,
   input  wire logic [15:0]         req_requested_speed,
   input  wire logic [15:0]         req_pulse_count,
   input  wire logic                req_home_switch,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [3:0]               rsp_status_code,
   output logic [1:0]               rsp_motor_action,
   output logic [1:0]               rsp_power_action,
   output logic                     rsp_speed_valid,
   output logic signed [31:0]       rsp_speed_command,
   output logic signed [31:0]       rsp_current_position,
   output logic                     rsp_moving_backward
);
   localparam int PW = POS_WIDTH;
   localparam int EW = ((PW > 32) ? PW : 32) + 2;
   localparam int DW = EW + 2;
   localparam logic signed [DW-1:0] DMAX = DW'(32'sh7fffffff);
   localparam logic signed [DW-1:0] DMIN = DW'(-32'sh7fffffff - 32'sd1);

   // configuration
   logic [15:0]        band_ff;
   logic signed [31:0] lim_min_ff, lim_max_ff, home_ofs_ff;
   logic [15:0]        home_spd_ff, floor_ff;
   logic [23:0]        sd_ff;
   logic               home_rev_ff;

   // axis state
   logic signed [PW-1:0] axis_ff, axis_in, last_ff, last_in, tgt_ff, tgt_in;
   logic [15:0]          tspd_ff, tspd_in;
   logic signed [31:0]   drive_ff, drive_in;
   apc_pkg::status_type  stat_ff, stat_in;
   apc_pkg::mode_type    mode_ff, mode_in;
   logic                 bwd_ff, bwd_in, ref_ff, ref_in;

   // captured request
   logic [3:0]         act_ff;
   logic signed [31:0] goal_ff;
   logic [15:0]        spd_ff, cnt_ff;
   logic               sw_ff;

   // evaluated terms
   logic signed [EW-1:0] tdiff_ff, rem_ff, meas_ff, mdiff_ff, mrem_ff, hrem_ff;
   logic signed [PW-1:0] hpos_ff, npos_ff, mgoal_ff;
   logic signed [EW-1:0] tdiff_c, mdiff_c, hneg_c, meas_c;
   logic signed [PW-1:0] npos_c;

   // result register
   logic                 rv_ff, rv_in;
   logic [3:0]           o_stat_ff;
   logic [1:0]           o_motor_ff, o_power_ff;
   logic                 o_sv_ff;
   logic signed [31:0]   o_drive_ff, o_pos_ff;
   logic                 o_bwd_ff;

   // divider
   logic [apc_pkg::PROD_WIDTH-1:0] prod, quo;
   logic                           div_done;

   logic signed [EW-1:0] half_e;

   function automatic logic signed [EW-1:0] absv(input logic signed [EW-1:0] v);
      return v[EW-1] ? -v : v;
   endfunction

   assign half_e = EW'({1'b0, band_ff[15:1]});

   // ---------------------------------------------------------------- eval
   always_comb begin
      tdiff_c = EW'(tgt_ff) - EW'(axis_ff);
      mdiff_c = EW'(PW'(goal_ff)) - EW'(axis_ff);
      hneg_c  = -EW'(home_ofs_ff);
      meas_c  = EW'(axis_ff) - EW'(last_ff);
      if (bwd_ff) npos_c = PW'(EW'(axis_ff) - EW'({1'b0, cnt_ff}));
      else        npos_c = PW'(EW'(axis_ff) + EW'({1'b0, cnt_ff}));
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff  <= req_action;
         goal_ff <= req_goal_position;
         spd_ff  <= req_requested_speed;
         cnt_ff  <= req_pulse_count;
         sw_ff   <= req_home_switch;
      end
      if (cmd.eval) begin
         tdiff_ff <= tdiff_c;
         rem_ff   <= absv(tdiff_c);
         meas_ff  <= absv(meas_c);
         mdiff_ff <= mdiff_c;
         mrem_ff  <= absv(mdiff_c);
         mgoal_ff <= PW'(goal_ff);
         hpos_ff  <= PW'(hneg_c);
         hrem_ff  <= absv(EW'(PW'(hneg_c)));
         npos_ff  <= npos_c;
      end
   end

   assign sts.need_div = (act_ff == apc_pkg::ACT_TICK) && (mode_ff == apc_pkg::MODE_POS)
                         && (rem_ff > half_e) && (rem_ff <= EW'({1'b0, sd_ff}));
   assign sts.div_done = div_done;
   assign sts.out_free = !rv_ff || !rsp_stall;

   assign prod = apc_pkg::PROD_WIDTH'(rem_ff[apc_pkg::SD_WIDTH-1:0]) *
                 apc_pkg::PROD_WIDTH'(tspd_ff);

   apc_div #(
      .NUM_W(apc_pkg::PROD_WIDTH),
      .DEN_W(apc_pkg::SD_WIDTH)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend(prod),
      .divisor (sd_ff),
      .quotient(quo),
      .done    (div_done)
   );

   // ---------------------------------------------------------------- commit
   logic signed [EW-1:0] cmd_e, npos_e, axis_e, nrem;
   logic signed [DW-1:0] dsum;
   logic                 add_en, jog_ok, jog_fwd;
   apc_pkg::motor_type   motor;
   apc_pkg::power_type   power;

   always_comb begin
      axis_in  = axis_ff;
      last_in  = last_ff;
      tgt_in   = tgt_ff;
      tspd_in  = tspd_ff;
      drive_in = drive_ff;
      stat_in  = stat_ff;
      mode_in  = mode_ff;
      bwd_in   = bwd_ff;
      ref_in   = ref_ff;
      motor    = apc_pkg::MA_NONE;
      power    = apc_pkg::PA_NONE;
      add_en   = 1'b0;
      cmd_e    = EW'({1'b0, tspd_ff});
      axis_e   = EW'(axis_ff);
      npos_e   = EW'(npos_ff);
      nrem     = absv(EW'(tgt_ff) - npos_e);
      jog_fwd  = (act_ff == apc_pkg::ACT_JOG_FWD);
      jog_ok   = (stat_ff == apc_pkg::ST_NOTINPOS) || (stat_ff == apc_pkg::ST_INPOS)
                 || (stat_ff == apc_pkg::ST_MOVING);
      if (stat_ff == apc_pkg::ST_LIMIT) begin
         jog_ok = jog_fwd ? (axis_e < EW'(lim_max_ff)) : (axis_e > EW'(lim_min_ff));
      end

      unique case (act_ff)
         apc_pkg::ACT_ENABLE: begin
            if (stat_ff == apc_pkg::ST_IDLE) begin
               if (!ref_ff)             stat_in = apc_pkg::ST_NOREF;
               else if (rem_ff <= half_e) stat_in = apc_pkg::ST_INPOS;
               else                     stat_in = apc_pkg::ST_NOTINPOS;
               power = apc_pkg::PA_ENABLE;
            end
         end
         apc_pkg::ACT_DISABLE: begin
            stat_in = apc_pkg::ST_IDLE;
            power   = apc_pkg::PA_DISABLE;
         end
         apc_pkg::ACT_HOME: begin
            if (stat_ff != apc_pkg::ST_IDLE && stat_ff != apc_pkg::ST_MOVING
                && stat_ff != apc_pkg::ST_HOMING) begin
               motor    = home_rev_ff ? apc_pkg::MA_BACK : apc_pkg::MA_FWD;
               bwd_in   = home_rev_ff;
               tspd_in  = home_spd_ff;
               stat_in  = apc_pkg::ST_HOMING;
               drive_in = '0;
               mode_in  = apc_pkg::MODE_HOME;
            end
         end
         apc_pkg::ACT_MOVE: begin
            if (jog_ok && stat_ff != apc_pkg::ST_LIMIT) begin
               tgt_in = mgoal_ff;
               if (mrem_ff < half_e) begin
                  stat_in = apc_pkg::ST_INPOS;
               end else begin
                  drive_in = '0;
                  motor    = (mdiff_ff > 0) ? apc_pkg::MA_FWD : apc_pkg::MA_BACK;
                  bwd_in   = !(mdiff_ff > 0);
                  stat_in  = apc_pkg::ST_MOVING;
                  tspd_in  = spd_ff;
                  mode_in  = apc_pkg::MODE_POS;
               end
            end
         end
         apc_pkg::ACT_STOP: begin
            motor  = apc_pkg::MA_BRAKE;
            tgt_in = axis_ff;
            if (stat_ff == apc_pkg::ST_JOGF || stat_ff == apc_pkg::ST_JOGB)
               stat_in = apc_pkg::ST_INPOS;
         end
         apc_pkg::ACT_JOG_FWD, apc_pkg::ACT_JOG_BCK: begin
            if (axis_e <= EW'(lim_max_ff) && jog_ok) begin
               tgt_in   = axis_ff;
               tspd_in  = spd_ff;
               drive_in = '0;
               motor    = jog_fwd ? apc_pkg::MA_FWD : apc_pkg::MA_BACK;
               bwd_in   = !jog_fwd;
               stat_in  = jog_fwd ? apc_pkg::ST_JOGF : apc_pkg::ST_JOGB;
            end
            mode_in = apc_pkg::MODE_JOG;
         end
         apc_pkg::ACT_TICK: begin
            unique case (mode_ff)
               apc_pkg::MODE_HOME: begin
                  if (sw_ff) begin
                     // home switch: rebase position, then return to zero
                     motor   = apc_pkg::MA_BRAKE;
                     axis_in = hpos_ff;
                     last_in = hpos_ff;
                     ref_in  = 1'b1;
                     tgt_in  = '0;
                     if (hrem_ff < half_e) begin
                        stat_in = apc_pkg::ST_INPOS;
                     end else begin
                        drive_in = '0;
                        motor    = hpos_ff[PW-1] ? apc_pkg::MA_FWD : apc_pkg::MA_BACK;
                        bwd_in   = !hpos_ff[PW-1];
                        stat_in  = apc_pkg::ST_MOVING;
                        tspd_in  = home_spd_ff;
                        mode_in  = apc_pkg::MODE_POS;
                     end
                  end else begin
                     add_en = 1'b1;
                  end
               end
               apc_pkg::MODE_POS: begin
                  if (rem_ff <= half_e) begin
                     stat_in = apc_pkg::ST_INPOS;
                  end else begin
                     motor  = (tdiff_ff > 0) ? apc_pkg::MA_FWD : apc_pkg::MA_BACK;
                     bwd_in = !(tdiff_ff > 0);
                     if (rem_ff <= EW'({1'b0, sd_ff}))
                        cmd_e = EW'({1'b0, quo[apc_pkg::SPD_WIDTH-1:0]});
                     if (cmd_e < EW'({1'b0, floor_ff}))
                        cmd_e = EW'({1'b0, floor_ff});
                     add_en  = 1'b1;
                     stat_in = apc_pkg::ST_MOVING;
                  end
               end
               apc_pkg::MODE_JOG:  add_en = 1'b1;
               default:            ;
            endcase
         end
         apc_pkg::ACT_PULSES: begin
            if (stat_ff != apc_pkg::ST_HOMING) begin
               axis_in = npos_ff;
               if (bwd_ff ? (npos_e < EW'(lim_min_ff)) : (npos_e > EW'(lim_max_ff))) begin
                  motor   = apc_pkg::MA_BRAKE;
                  stat_in = apc_pkg::ST_LIMIT;
               end
               if (nrem <= half_e) motor = apc_pkg::MA_BRAKE;
            end
         end
         default: ;
      endcase

      // saturating integration of the speed error
      dsum = DW'(drive_ff) + DW'(cmd_e) - DW'(meas_ff);
      if (add_en) begin
         last_in = axis_ff;
         if (dsum > DMAX)      drive_in = 32'sh7fffffff;
         else if (dsum < DMIN) drive_in = DMIN[31:0];
         else                  drive_in = dsum[31:0];
      end
   end

   always_comb begin
      rv_in = rv_ff;
      if (cmd.commit)     rv_in = 1'b1;
      else if (!rsp_stall) rv_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff     <= apc_pkg::BAND_RESET;
         lim_min_ff  <= apc_pkg::LIMIT_MIN_RESET;
         lim_max_ff  <= apc_pkg::LIMIT_MAX_RESET;
         home_spd_ff <= apc_pkg::HOME_SPEED_RESET;
         home_ofs_ff <= apc_pkg::HOME_OFFSET_RESET;
         floor_ff    <= apc_pkg::FLOOR_RESET;
         sd_ff       <= apc_pkg::SLOWDOWN_RESET;
         home_rev_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (apc_pkg::csr_index_type'(csr_index))
            apc_pkg::CSR_BAND:       band_ff     <= csr_wdata[15:0];
            apc_pkg::CSR_LIMIT_MIN:  lim_min_ff  <= csr_wdata;
            apc_pkg::CSR_LIMIT_MAX:  lim_max_ff  <= csr_wdata;
            apc_pkg::CSR_HOME_SPEED: home_spd_ff <= csr_wdata[15:0];
            apc_pkg::CSR_HOME_OFS:   home_ofs_ff <= csr_wdata;
            apc_pkg::CSR_FLOOR:      floor_ff    <= csr_wdata[15:0];
            apc_pkg::CSR_SLOWDOWN:   sd_ff       <= csr_wdata[23:0];
            apc_pkg::CSR_HOME_REV:   home_rev_ff <= csr_wdata[0];
            default:                 ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff  <= '0;
         last_ff  <= '0;
         tgt_ff   <= '0;
         tspd_ff  <= apc_pkg::HOME_SPEED_RESET;
         drive_ff <= '0;
         stat_ff  <= apc_pkg::ST_IDLE;
         mode_ff  <= apc_pkg::MODE_NONE;
         bwd_ff   <= 1'b0;
         ref_ff   <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         rv_ff <= rv_in;
         if (cmd.commit) begin
            axis_ff  <= axis_in;
            last_ff  <= last_in;
            tgt_ff   <= tgt_in;
            tspd_ff  <= tspd_in;
            drive_ff <= drive_in;
            stat_ff  <= stat_in;
            mode_ff  <= mode_in;
            bwd_ff   <= bwd_in;
            ref_ff   <= ref_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         o_stat_ff  <= stat_in;
         o_motor_ff <= motor;
         o_power_ff <= power;
         o_sv_ff    <= add_en;
         o_drive_ff <= drive_in;
         o_pos_ff   <= 32'(EW'(axis_in));
         o_bwd_ff   <= bwd_in;
      end
   end

   assign rsp_valid            = rv_ff;
   assign rsp_status_code      = o_stat_ff;
   assign rsp_motor_action     = o_motor_ff;
   assign rsp_power_action     = o_power_ff;
   assign rsp_speed_valid      = o_sv_ff;
   assign rsp_speed_command    = o_drive_ff;
   assign rsp_current_position = o_pos_ff;
   assign rsp_moving_backward  = o_bwd_ff;

endmodule
`default_nettype wire
